@@ src/c_escape_string_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// c_escape_string_decoder_defines
// assertion macros shared by the escape decoder modules
// ----------------------------------------------------------------------------
`ifndef C_ESCAPE_STRING_DECODER_DEFINES_SVH
`define C_ESCAPE_STRING_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define CESD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cesd assertion failed");

// next-cycle implication, checked out of reset
`define CESD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cesd assertion failed");

`else

`define CESD_ASSERT_IMPL(lbl, ante, cons)
`define CESD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ src/cesd_pkg.sv @@
// ----------------------------------------------------------------------------
// cesd_pkg
// types and character codes of the escape string decoder
// ----------------------------------------------------------------------------
`default_nettype none

package cesd_pkg;

    // decoder mode, one-hot
    typedef enum logic [5:0] {
        MODE_NORMAL = 6'b000001,
        MODE_ESC    = 6'b000010,
        MODE_OCT1   = 6'b000100,
        MODE_OCT2   = 6'b001000,
        MODE_HEX0   = 6'b010000,
        MODE_HEX1   = 6'b100000
    } t_mode;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_string;
        logic       last_in_run;
    } t_result;

    // up to two results from one character
    typedef struct packed {
        logic [1:0] count;
        t_result    slot0;
        t_result    slot1;
    } t_push;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LC_A      = 8'h61;
    localparam logic [7:0] CH_LC_F      = 8'h66;
    localparam logic [7:0] CH_UC_A      = 8'h41;
    localparam logic [7:0] CH_UC_F      = 8'h46;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_V         = 8'h76;

    localparam logic [7:0] CODE_LF = 8'h0A;
    localparam logic [7:0] CODE_CR = 8'h0D;
    localparam logic [7:0] CODE_BS = 8'h08;
    localparam logic [7:0] CODE_HT = 8'h09;
    localparam logic [7:0] CODE_FF = 8'h0C;
    localparam logic [7:0] CODE_VT = 8'h0B;

endpackage

`default_nettype wire

@@ src/c_escape_string_decoder.sv @@
// ----------------------------------------------------------------------------
// c_escape_string_decoder
// C string escape decoder, one character per beat in, decoded bytes out
// ----------------------------------------------------------------------------
// The decoder takes one character per cycle when not stalled and turns C escapes (\n \r \b
// \t \f \v, one to three octal digits, \x with up to two hex digits, and a
// backslash before any other character) into raw bytes. A zero character
// ends the string: a pending escape byte is flushed and an end marker beat
// follows. A character gives zero, one or two result beats; last_in_run
// marks the final beat of each character. Input beats are registered, then
// decoded combinationally into a four-entry result queue, so the first result
// beat of a character passes the input register and the queue before it is
// presented. Sustained rate is one character per cycle while the output
// drains one beat per cycle; the output side moves one beat per cycle, so
// characters that give two beats (an escape ended early, or a flush before
// the terminator) cost one extra output beat. The input stalls only while
// the held character waits for two free queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

`include "c_escape_string_decoder_defines.svh"

module c_escape_string_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // character beats
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_char_in,
    // result beats
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_data_byte,
    output logic            o_byte_valid,
    output logic            o_end_of_string,
    output logic            o_last_in_run
);

    // input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_char;

    logic              room2;
    logic              advance;
    logic              in_take;
    cesd_pkg::t_push   push;
    cesd_pkg::t_result head;

    // held character moves on once the queue can take its worst case
    assign advance    = r_in_valid && room2;
    assign o_in_stall = r_in_valid && !room2;
    assign in_take    = i_in_valid && !o_in_stall;
    assign n_in_valid = in_take || (r_in_valid && !advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= i_char_in;
        end
    end

    // escape state and decode
    cesd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_char  (r_in_char),
        .o_push  (push)
    );

    // result queue feeding the output beats
    cesd_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (!i_out_stall),
        .o_valid  (o_out_valid),
        .o_result (head),
        .o_room2  (room2)
    );

    assign o_data_byte     = head.data_byte;
    assign o_byte_valid    = head.byte_valid;
    assign o_end_of_string = head.end_of_string;
    assign o_last_in_run   = head.last_in_run;

    // end marker carries no byte and closes its character
    `CESD_ASSERT_IMPL(a_eos_shape, o_out_valid && o_end_of_string,
        !o_byte_valid && o_last_in_run && (o_data_byte == 8'h00))
    // a held character never vanishes while stalled
    `CESD_ASSERT_NEXT(a_hold_stalled, o_in_stall, r_in_valid)

endmodule

`default_nettype wire

@@ src/cesd_decode.sv @@
// ----------------------------------------------------------------------------
// cesd_decode
// escape state and per-character decode into up to two results
// ----------------------------------------------------------------------------
`default_nettype none

`include "c_escape_string_decoder_defines.svh"

module cesd_decode (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire logic [7:0]     i_char,
    output cesd_pkg::t_push     o_push
);

    cesd_pkg::t_mode r_mode, n_mode;
    logic [7:0]      r_pend, n_pend;

    logic       is_oct, is_hex;
    logic [3:0] hex_val;
    logic [7:0] esc_byte;
    logic       flush_en, main_en, main_bv, main_eos;
    logic [7:0] flush_byte, main_byte;
    logic [1:0] cnt;

    always_comb begin
        is_oct = i_char inside {[cesd_pkg::CH_ZERO:cesd_pkg::CH_SEVEN]};
        is_hex = 1'b1;
        if (i_char inside {[cesd_pkg::CH_ZERO:cesd_pkg::CH_NINE]}) begin
            hex_val = i_char[3:0];
        end else if (i_char inside {[cesd_pkg::CH_LC_A:cesd_pkg::CH_LC_F],
                                    [cesd_pkg::CH_UC_A:cesd_pkg::CH_UC_F]}) begin
            // low nibble of a..f / A..F is 1..6
            hex_val = i_char[3:0] + 4'd9;
        end else begin
            hex_val = 4'd0;
            is_hex  = 1'b0;
        end
    end

    always_comb begin
        case (i_char)
            cesd_pkg::CH_N: esc_byte = cesd_pkg::CODE_LF;
            cesd_pkg::CH_R: esc_byte = cesd_pkg::CODE_CR;
            cesd_pkg::CH_B: esc_byte = cesd_pkg::CODE_BS;
            cesd_pkg::CH_T: esc_byte = cesd_pkg::CODE_HT;
            cesd_pkg::CH_F: esc_byte = cesd_pkg::CODE_FF;
            cesd_pkg::CH_V: esc_byte = cesd_pkg::CODE_VT;
            default:        esc_byte = i_char;
        endcase
    end

    always_comb begin
        flush_en   = 1'b0;
        flush_byte = r_pend;
        main_en    = 1'b0;
        main_byte  = i_char;
        main_bv    = 1'b1;
        main_eos   = 1'b0;
        n_mode     = r_mode;
        n_pend     = r_pend;

        // plain character handling, also used after an early-ended escape
        if (i_char == cesd_pkg::CH_BACKSLASH) begin
            n_mode = cesd_pkg::MODE_ESC;
        end else begin
            main_en = 1'b1;
            n_mode  = cesd_pkg::MODE_NORMAL;
        end

        if (i_char == cesd_pkg::CH_NUL) begin
            flush_en  = (r_mode == cesd_pkg::MODE_OCT1) || (r_mode == cesd_pkg::MODE_OCT2) ||
                        (r_mode == cesd_pkg::MODE_HEX0) || (r_mode == cesd_pkg::MODE_HEX1);
            if (r_mode == cesd_pkg::MODE_HEX0) begin
                flush_byte = cesd_pkg::CH_X;
            end
            main_en   = 1'b1;
            main_byte = 8'h00;
            main_bv   = 1'b0;
            main_eos  = 1'b1;
            n_mode    = cesd_pkg::MODE_NORMAL;
        end else begin
            case (r_mode)
                cesd_pkg::MODE_ESC: begin
                    if (is_oct) begin
                        main_en = 1'b0;
                        n_pend  = {5'd0, i_char[2:0]};
                        n_mode  = cesd_pkg::MODE_OCT1;
                    end else if (i_char == cesd_pkg::CH_X) begin
                        main_en = 1'b0;
                        n_pend  = 8'h00;
                        n_mode  = cesd_pkg::MODE_HEX0;
                    end else begin
                        main_en   = 1'b1;
                        main_byte = esc_byte;
                        n_mode    = cesd_pkg::MODE_NORMAL;
                    end
                end
                cesd_pkg::MODE_OCT1: begin
                    if (is_oct) begin
                        main_en = 1'b0;
                        n_pend  = {r_pend[4:0], i_char[2:0]};
                        n_mode  = cesd_pkg::MODE_OCT2;
                    end else begin
                        flush_en = 1'b1;
                    end
                end
                cesd_pkg::MODE_OCT2: begin
                    if (is_oct) begin
                        // third digit, truncated to a byte
                        main_en   = 1'b1;
                        main_byte = {r_pend[4:0], i_char[2:0]};
                        n_mode    = cesd_pkg::MODE_NORMAL;
                    end else begin
                        flush_en = 1'b1;
                    end
                end
                cesd_pkg::MODE_HEX0: begin
                    if (is_hex) begin
                        main_en = 1'b0;
                        n_pend  = {4'd0, hex_val};
                        n_mode  = cesd_pkg::MODE_HEX1;
                    end else begin
                        flush_en   = 1'b1;
                        flush_byte = cesd_pkg::CH_X;
                    end
                end
                cesd_pkg::MODE_HEX1: begin
                    if (is_hex) begin
                        main_en   = 1'b1;
                        main_byte = {r_pend[3:0], hex_val};
                        n_mode    = cesd_pkg::MODE_NORMAL;
                    end else begin
                        flush_en = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (n_mode == cesd_pkg::MODE_NORMAL) begin
            n_pend = 8'h00;
        end
    end

    always_comb begin
        cnt = {1'b0, flush_en} + {1'b0, main_en};

        o_push.slot0.data_byte     = flush_en ? flush_byte : main_byte;
        o_push.slot0.byte_valid    = flush_en ? 1'b1 : main_bv;
        o_push.slot0.end_of_string = flush_en ? 1'b0 : main_eos;
        o_push.slot0.last_in_run   = (cnt == 2'd1);

        o_push.slot1.data_byte     = main_byte;
        o_push.slot1.byte_valid    = main_bv;
        o_push.slot1.end_of_string = main_eos;
        o_push.slot1.last_in_run   = 1'b1;

        o_push.count = i_fire ? cnt : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= cesd_pkg::MODE_NORMAL;
            r_pend <= 8'h00;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
        end
    end

    // terminator always leaves the decoder clean
    `CESD_ASSERT_NEXT(a_eos_resets_state, i_fire && (i_char == cesd_pkg::CH_NUL),
        (r_mode == cesd_pkg::MODE_NORMAL) && (r_pend == 8'h00))
    // pending value only survives inside an escape
    `CESD_ASSERT_IMPL(a_pend_clear_normal, r_mode == cesd_pkg::MODE_NORMAL, r_pend == 8'h00)

endmodule

`default_nettype wire

@@ src/cesd_out_queue.sv @@
// ----------------------------------------------------------------------------
// cesd_out_queue
// small result queue, takes up to two results and gives one per beat
// ----------------------------------------------------------------------------
`default_nettype none

`include "c_escape_string_decoder_defines.svh"

module cesd_out_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cesd_pkg::t_push    i_push,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output cesd_pkg::t_result       o_result,
    output logic                    o_room2
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cesd_pkg::t_result r_entry [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  wr_ptr1;

    assign wr_ptr1  = r_wr_ptr + PTR_W'(1);
    assign o_valid  = (r_count != '0);
    assign o_result = r_entry[r_rd_ptr];
    assign o_room2  = (r_count <= CNT_W'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_entry[r_wr_ptr] <= i_push.slot0;
        end
        if (i_push.count == 2'd2) begin
            r_entry[wr_ptr1] <= i_push.slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push.count);
            r_rd_ptr <= r_rd_ptr + PTR_W'(i_pop && o_valid);
            r_count  <= r_count + CNT_W'(i_push.count) - CNT_W'(i_pop && o_valid);
        end
    end

    `CESD_ASSERT_IMPL(a_no_overflow, i_push.count != 2'd0,
        r_count <= CNT_W'(DEPTH) - CNT_W'(i_push.count))
    `CESD_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the C string escape decoder
// ----------------------------------------------------------------------------
// A queue of characters is built at time zero. It holds a short directed
// opening, then randomly chosen tokens: plain bytes, simple escapes, octal
// and hex escapes of every length, terminators and noise. A clocked driver
// presents the characters and a clocked monitor watches both channels. Each
// character taken by the decoder runs through a predictor that keeps its own
// decode mode and digit value, and the result beats it predicts are queued.
// Each result beat taken from the decoder is checked field by field against
// the oldest queued beat. Both sides idle at random, except for a calm window
// in the middle of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_CHARS   = 1300;
    localparam int IDLE_PCT       = 38;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int REPORT_LIMIT   = 10;
    // no idling on either side while this range of characters is taken
    localparam int CALM_FIRST     = 600;
    localparam int CALM_LAST      = 800;

    // directed opening: extremes of the byte, a control escape, a truncated
    // three-digit octal, a bare \x, an octal cut by a backslash that then
    // meets the terminator, a hex flushed by the terminator, a full hex
    // escape in mixed case and an octal flushed by the terminator
    localparam int DIRECTED_LEN = 27;
    localparam logic [7:0] DIRECTED [DIRECTED_LEN] = '{
        8'hFF, 8'h01,
        cesd_pkg::CH_BACKSLASH, cesd_pkg::CH_N,
        cesd_pkg::CH_BACKSLASH, cesd_pkg::CH_SEVEN, cesd_pkg::CH_SEVEN,
        cesd_pkg::CH_SEVEN,
        cesd_pkg::CH_BACKSLASH, cesd_pkg::CH_X, 8'h67,
        cesd_pkg::CH_BACKSLASH, 8'h31, cesd_pkg::CH_BACKSLASH, cesd_pkg::CH_NUL,
        cesd_pkg::CH_BACKSLASH, cesd_pkg::CH_X, cesd_pkg::CH_UC_F, cesd_pkg::CH_NUL,
        cesd_pkg::CH_BACKSLASH, cesd_pkg::CH_X, cesd_pkg::CH_LC_A, 8'h42,
        cesd_pkg::CH_BACKSLASH, 8'h34, 8'h35, cesd_pkg::CH_NUL
    };

    // ------------------------------------------------------------------------
    // dut signals, inputs driven to known values from the start
    // ------------------------------------------------------------------------
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_char_in   = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_data_byte;
    logic       o_byte_valid;
    logic       o_end_of_string;
    logic       o_last_in_run;

    c_escape_string_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_char_in       (i_char_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_data_byte     (o_data_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_string (o_end_of_string),
        .o_last_in_run   (o_last_in_run)
    );

    always begin
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    logic [7:0]        char_queue [$];     // characters still to be sent
    cesd_pkg::t_result decoded_queue [$];  // predicted result beats, oldest first
    cesd_pkg::t_result char_run [$];       // beats caused by the character in hand

    // predictor copy of the decoder state
    cesd_pkg::t_mode esc_mode  = cesd_pkg::MODE_NORMAL;
    logic [7:0]      esc_value = 8'h00;

    int chars_sent     = 0;  // written by the driver only
    int chars_taken    = 0;  // written by the monitor only
    int beats_checked  = 0;
    int strings_closed = 0;
    int double_beats   = 0;
    int fail_count     = 0;
    int idle_cycles    = 0;

    logic calm;
    assign calm = (chars_taken >= CALM_FIRST) && (chars_taken < CALM_LAST);

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic logic is_oct(input logic [7:0] c);
        return (c >= cesd_pkg::CH_ZERO) && (c <= cesd_pkg::CH_SEVEN);
    endfunction

    // value of a hex digit, -1 for anything else
    function automatic int hex_val(input logic [7:0] c);
        if (c >= cesd_pkg::CH_ZERO && c <= cesd_pkg::CH_NINE)
            return int'(c - cesd_pkg::CH_ZERO);
        if (c >= cesd_pkg::CH_LC_A && c <= cesd_pkg::CH_LC_F)
            return int'(c - cesd_pkg::CH_LC_A) + 10;
        if (c >= cesd_pkg::CH_UC_A && c <= cesd_pkg::CH_UC_F)
            return int'(c - cesd_pkg::CH_UC_A) + 10;
        return -1;
    endfunction

    // byte for a backslash followed by c
    function automatic logic [7:0] escaped_byte(input logic [7:0] c);
        case (c)
            cesd_pkg::CH_N: return cesd_pkg::CODE_LF;
            cesd_pkg::CH_R: return cesd_pkg::CODE_CR;
            cesd_pkg::CH_B: return cesd_pkg::CODE_BS;
            cesd_pkg::CH_T: return cesd_pkg::CODE_HT;
            cesd_pkg::CH_F: return cesd_pkg::CODE_FF;
            cesd_pkg::CH_V: return cesd_pkg::CODE_VT;
            default:        return c;
        endcase
    endfunction

    function automatic void emit(input logic [7:0] b, input logic v, input logic e);
        cesd_pkg::t_result r;
        r.data_byte     = b;
        r.byte_valid    = v;
        r.end_of_string = e;
        r.last_in_run   = 1'b0;
        char_run.push_back(r);
    endfunction

    // a nonzero character seen outside any escape
    function automatic void plain_char(input logic [7:0] c);
        if (c == cesd_pkg::CH_BACKSLASH)
            esc_mode = cesd_pkg::MODE_ESC;
        else
            emit(c, 1'b1, 1'b0);
    endfunction

    // advance the predictor by one character and queue the beats it causes
    function automatic void decode_char(input logic [7:0] c);
        cesd_pkg::t_mode was;
        int              h;
        logic [3:0]      nib;
        was = esc_mode;
        h   = hex_val(c);
        nib = h[3:0];
        char_run.delete();
        if (c == cesd_pkg::CH_NUL) begin
            // flush any escape with a pending byte, then the end marker
            case (was)
                cesd_pkg::MODE_OCT1, cesd_pkg::MODE_OCT2, cesd_pkg::MODE_HEX1:
                    emit(esc_value, 1'b1, 1'b0);
                cesd_pkg::MODE_HEX0:
                    emit(cesd_pkg::CH_X, 1'b1, 1'b0);
                default: ;
            endcase
            emit(cesd_pkg::CH_NUL, 1'b0, 1'b1);
            esc_mode  = cesd_pkg::MODE_NORMAL;
            esc_value = 8'h00;
            strings_closed++;
        end else begin
            esc_mode = cesd_pkg::MODE_NORMAL;
            case (was)
                cesd_pkg::MODE_ESC: begin
                    if (is_oct(c)) begin
                        esc_value = c - cesd_pkg::CH_ZERO;
                        esc_mode  = cesd_pkg::MODE_OCT1;
                    end else if (c == cesd_pkg::CH_X) begin
                        esc_value = 8'h00;
                        esc_mode  = cesd_pkg::MODE_HEX0;
                    end else begin
                        emit(escaped_byte(c), 1'b1, 1'b0);
                    end
                end
                cesd_pkg::MODE_OCT1: begin
                    if (is_oct(c)) begin
                        esc_value = {esc_value[4:0], c[2:0]};
                        esc_mode  = cesd_pkg::MODE_OCT2;
                    end else begin
                        emit(esc_value, 1'b1, 1'b0);
                        plain_char(c);
                    end
                end
                cesd_pkg::MODE_OCT2: begin
                    // third digit: upper bits fall off the byte
                    if (is_oct(c)) begin
                        emit({esc_value[4:0], c[2:0]}, 1'b1, 1'b0);
                    end else begin
                        emit(esc_value, 1'b1, 1'b0);
                        plain_char(c);
                    end
                end
                cesd_pkg::MODE_HEX0: begin
                    if (h >= 0) begin
                        esc_value = {4'h0, nib};
                        esc_mode  = cesd_pkg::MODE_HEX1;
                    end else begin
                        emit(cesd_pkg::CH_X, 1'b1, 1'b0);
                        plain_char(c);
                    end
                end
                cesd_pkg::MODE_HEX1: begin
                    if (h >= 0) begin
                        emit({esc_value[3:0], nib}, 1'b1, 1'b0);
                    end else begin
                        emit(esc_value, 1'b1, 1'b0);
                        plain_char(c);
                    end
                end
                default: plain_char(c);
            endcase
            if (esc_mode == cesd_pkg::MODE_NORMAL)
                esc_value = 8'h00;
        end
        if (char_run.size() > 0)
            char_run[char_run.size() - 1].last_in_run = 1'b1;
        if (char_run.size() == 2)
            double_beats++;
        foreach (char_run[i])
            decoded_queue.push_back(char_run[i]);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus tokens
    // ------------------------------------------------------------------------
    function automatic logic [7:0] rand_hex_digit();
        case ($urandom_range(0, 2))
            0:       return cesd_pkg::CH_ZERO + 8'($urandom_range(0, 9));
            1:       return cesd_pkg::CH_LC_A + 8'($urandom_range(0, 5));
            default: return cesd_pkg::CH_UC_A + 8'($urandom_range(0, 5));
        endcase
    endfunction

    // one well-formed piece of a string, or now and then some noise
    function automatic void add_token();
        int kind;
        int digits;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            char_queue.push_back(8'($urandom_range(1, 255)));
        end else if (kind < 48) begin
            char_queue.push_back(cesd_pkg::CH_BACKSLASH);
            case ($urandom_range(0, 7))
                0:       char_queue.push_back(cesd_pkg::CH_N);
                1:       char_queue.push_back(cesd_pkg::CH_R);
                2:       char_queue.push_back(cesd_pkg::CH_B);
                3:       char_queue.push_back(cesd_pkg::CH_T);
                4:       char_queue.push_back(cesd_pkg::CH_F);
                5:       char_queue.push_back(cesd_pkg::CH_V);
                6:       char_queue.push_back(cesd_pkg::CH_BACKSLASH);
                default: char_queue.push_back(8'($urandom_range(1, 255)));
            endcase
        end else if (kind < 66) begin
            // octal escape of one to three digits, cut by whatever follows
            char_queue.push_back(cesd_pkg::CH_BACKSLASH);
            digits = $urandom_range(1, 3);
            repeat (digits)
                char_queue.push_back(cesd_pkg::CH_ZERO + 8'($urandom_range(0, 7)));
        end else if (kind < 84) begin
            // hex escape with none, one or two digits
            char_queue.push_back(cesd_pkg::CH_BACKSLASH);
            char_queue.push_back(cesd_pkg::CH_X);
            digits = $urandom_range(0, 2);
            repeat (digits)
                char_queue.push_back(rand_hex_digit());
        end else if (kind < 94) begin
            char_queue.push_back(cesd_pkg::CH_NUL);
        end else begin
            char_queue.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // ------------------------------------------------------------------------
    // character driver: new beat only once the previous one was taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (chars_sent == chars_taken) begin
            if (char_queue.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_char_in  <= char_queue.pop_front();
                i_in_valid <= 1'b1;
                chars_sent++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // monitor: predict on taken characters, check taken result beats
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cesd_pkg::t_result got;
        cesd_pkg::t_result want;
        logic              in_beat;
        logic              out_beat;
        in_beat  = i_rst_n && i_in_valid && !o_in_stall;
        out_beat = i_rst_n && o_out_valid && !i_out_stall;

        if (in_beat) begin
            decode_char(i_char_in);
            chars_taken++;
        end

        if (out_beat) begin
            got.data_byte     = o_data_byte;
            got.byte_valid    = o_byte_valid;
            got.end_of_string = o_end_of_string;
            got.last_in_run   = o_last_in_run;
            if (decoded_queue.size() == 0) begin
                if (fail_count < REPORT_LIMIT)
                    $display("beat %0d: unexpected result byte/valid/eos/last %02h/%b/%b/%b",
                             beats_checked, got.data_byte, got.byte_valid,
                             got.end_of_string, got.last_in_run);
                fail_count++;
            end else begin
                want = decoded_queue.pop_front();
                if (got.data_byte !== want.data_byte
                        || got.byte_valid !== want.byte_valid
                        || got.end_of_string !== want.end_of_string
                        || got.last_in_run !== want.last_in_run) begin
                    // fields in order byte/valid/eos/last
                    if (fail_count < REPORT_LIMIT)
                        $display("beat %0d: expected %02h/%b/%b/%b got %02h/%b/%b/%b",
                                 beats_checked, want.data_byte, want.byte_valid,
                                 want.end_of_string, want.last_in_run,
                                 got.data_byte, got.byte_valid,
                                 got.end_of_string, got.last_in_run);
                    fail_count++;
                end
            end
            beats_checked++;
        end

        // watchdog on cycles with no beat on either channel
        if (in_beat || out_beat || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d beats still expected",
                     idle_cycles, decoded_queue.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus build, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        foreach (DIRECTED[i])
            char_queue.push_back(DIRECTED[i]);
        while (char_queue.size() < DIRECTED_LEN + RANDOM_CHARS)
            add_token();
        // close the last string so every escape is flushed
        char_queue.push_back(cesd_pkg::CH_NUL);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (char_queue.size() != 0 || chars_sent != chars_taken
                || decoded_queue.size() != 0)
            @(negedge i_clk);
        // let any late or extra beat show up
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("run sent %0d characters in %0d terminated strings", chars_taken,
                 strings_closed);
        $display("checked %0d result beats, %0d characters gave two beats, %0d failures",
                 beats_checked, double_beats, fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
